// ===== hw/rtl/trd_pkg.sv =====
// ----------------------------------------------------------------------------
// trd_pkg: shared types and constants for the touch report decoder
// Register indexes, reset values, the config and touch structs and the
// coordinate mask helper used across the block.
// ----------------------------------------------------------------------------
package trd_pkg;

    // coordinate and port widths
    localparam int COORD_BITS_DEF = 12;
    localparam int PORT_COORD_W   = 12;
    localparam int HOLD_W         = 16;
    localparam int TIME_W         = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int BYTE_W         = 8;
    localparam int REP_BYTES      = 7;
    localparam int IN_TDATA_W     = REP_BYTES * BYTE_W + TIME_W;
    localparam int OUT_TDATA_W    = 2 * PORT_COORD_W;

    // touch count limits
    localparam logic [3:0] COUNT_MIN = 4'd1;
    localparam logic [3:0] COUNT_MAX = 4'd10;

    // reset values
    localparam logic [HOLD_W-1:0]       HOLD_RESET  = 16'd150;
    localparam logic [PORT_COORD_W-1:0] LIMIT_RESET = 12'hFFF;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIRROR_X = 3'd0,
        REG_MIRROR_Y = 3'd1,
        REG_SWAP     = 3'd2,
        REG_X_LIMIT  = 3'd3,
        REG_Y_LIMIT  = 3'd4,
        REG_HOLD_MS  = 3'd5
    } t_reg_idx;

    // configuration bundle
    typedef struct packed {
        logic                    mirror_x_en;
        logic                    mirror_y_en;
        logic                    swap_axes;
        logic [PORT_COORD_W-1:0] x_limit;
        logic [PORT_COORD_W-1:0] y_limit;
        logic [HOLD_W-1:0]       hold_ms;
    } t_cfg;

    // one point with its press or active flag
    typedef struct packed {
        logic                    flag;
        logic [PORT_COORD_W-1:0] x;
        logic [PORT_COORD_W-1:0] y;
    } t_touch;

    // mask that keeps the low coordinate bits, clamped to the port width
    function automatic logic [PORT_COORD_W-1:0] coord_mask(input int bits);
        int b;
        b = (bits < PORT_COORD_W) ? bits : PORT_COORD_W;
        return {PORT_COORD_W{1'b1}} >> (PORT_COORD_W - b);
    endfunction

endpackage

// ===== hw/rtl/touch_report_decode_release_hold.sv =====
// ----------------------------------------------------------------------------
// touch_report_decode_release_hold: touch report decoder with release hold
// Decodes one controller poll per word into a pressed flag and a mirrored,
// swapped point, holding the press for a configured time after release.
//
//   channel   dir  handshake                  payload
//   s_axis    in   i_s_tvalid / o_s_tready    tuser read_ok, tdata bytes + now
//   m_axis    out  o_m_tvalid / i_m_tready    tuser touch_active, tdata x, y
//   cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One word per cycle while the output is not stalled; a poll passes through
// the input register and then the result register.
// The hold state updates as a word moves from the input register to the
// result register, so decode, timer compare and transform sit in one stage.
// Reset is synchronous and clears valid flags, hold state and config registers.
// A stalled output holds its word; the input register keeps one more word.
// ----------------------------------------------------------------------------
module touch_report_decode_release_hold #(
    parameter int COORD_BITS = trd_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic                              i_s_tuser,   // read_ok
    // rep_byte0..rep_byte6 [55:0], now_ms [87:56]
    input  logic [trd_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // master stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic                              o_m_tuser,   // touch_active
    // point_x [11:0], point_y [23:12]
    output logic [trd_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [trd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [trd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int BW = trd_pkg::BYTE_W;

    logic                              r_in_valid;
    logic                              r_in_ok;
    logic [trd_pkg::IN_TDATA_W-1:0]    r_in_data;
    logic                              r_out_valid;
    trd_pkg::t_touch                   r_out;
    logic                              w_out_free;
    logic                              w_advance;
    trd_pkg::t_cfg                     w_cfg;
    trd_pkg::t_touch                   w_touch;
    trd_pkg::t_touch                   w_state;
    trd_pkg::t_touch                   w_point;

    // handshake
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_advance;

    // config registers
    trd_cfg_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_ok   <= i_s_tuser;
            r_in_data <= i_s_tdata;
        end
    end

    // report decode
    trd_decode #(
        .COORD_BITS (COORD_BITS)
    ) u_decode (
        .i_read_ok   (r_in_ok),
        .i_rep_byte0 (r_in_data[0*BW +: BW]),
        .i_rep_byte1 (r_in_data[1*BW +: BW]),
        .i_rep_byte2 (r_in_data[2*BW +: BW]),
        .i_rep_byte3 (r_in_data[3*BW +: BW]),
        .i_rep_byte4 (r_in_data[4*BW +: BW]),
        .i_rep_byte5 (r_in_data[5*BW +: BW]),
        .i_rep_byte6 (r_in_data[6*BW +: BW]),
        .o_touch     (w_touch)
    );

    // press state and hold timer
    trd_hold u_hold (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_advance),
        .i_touch   (w_touch),
        .i_now_ms  (r_in_data[trd_pkg::REP_BYTES*BW +: trd_pkg::TIME_W]),
        .i_hold_ms (w_cfg.hold_ms),
        .o_state   (w_state)
    );

    // mirror and swap
    trd_xform u_xform (
        .i_cfg   (w_cfg),
        .i_state (w_state),
        .o_point (w_point)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_point;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.flag;
    assign o_m_tdata  = {r_out.y, r_out.x};

endmodule

// ===== hw/rtl/trd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// trd_cfg_regs: configuration register file
// Holds mirror, swap, limit and hold settings written over the config channel.
// ----------------------------------------------------------------------------
module trd_cfg_regs #(
    parameter int COORD_BITS = trd_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [trd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [trd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output trd_pkg::t_cfg                    o_cfg
);

    localparam logic [trd_pkg::PORT_COORD_W-1:0] MASK = trd_pkg::coord_mask(COORD_BITS);

    trd_pkg::t_cfg r_cfg;
    trd_pkg::t_cfg n_cfg;
    logic [trd_pkg::PORT_COORD_W-1:0] w_coord;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;
    assign w_coord     = i_cfg_data[trd_pkg::PORT_COORD_W-1:0] & MASK;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                trd_pkg::REG_MIRROR_X: n_cfg.mirror_x_en = i_cfg_data[0];
                trd_pkg::REG_MIRROR_Y: n_cfg.mirror_y_en = i_cfg_data[0];
                trd_pkg::REG_SWAP:     n_cfg.swap_axes   = i_cfg_data[0];
                trd_pkg::REG_X_LIMIT:  n_cfg.x_limit     = w_coord;
                trd_pkg::REG_Y_LIMIT:  n_cfg.y_limit     = w_coord;
                trd_pkg::REG_HOLD_MS:  n_cfg.hold_ms     = i_cfg_data;
                default:               n_cfg             = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mirror_x_en <= 1'b0;
            r_cfg.mirror_y_en <= 1'b0;
            r_cfg.swap_axes   <= 1'b0;
            r_cfg.x_limit     <= trd_pkg::LIMIT_RESET & MASK;
            r_cfg.y_limit     <= trd_pkg::LIMIT_RESET & MASK;
            r_cfg.hold_ms     <= trd_pkg::HOLD_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== hw/rtl/trd_decode.sv =====
// ----------------------------------------------------------------------------
// trd_decode: report parser
// Finds the touch count byte and extracts the X and Y coordinates behind it.
// ----------------------------------------------------------------------------
module trd_decode #(
    parameter int COORD_BITS = trd_pkg::COORD_BITS_DEF
) (
    input  logic                        i_read_ok,
    input  logic [trd_pkg::BYTE_W-1:0]  i_rep_byte0,
    input  logic [trd_pkg::BYTE_W-1:0]  i_rep_byte1,
    input  logic [trd_pkg::BYTE_W-1:0]  i_rep_byte2,
    input  logic [trd_pkg::BYTE_W-1:0]  i_rep_byte3,
    input  logic [trd_pkg::BYTE_W-1:0]  i_rep_byte4,
    input  logic [trd_pkg::BYTE_W-1:0]  i_rep_byte5,
    input  logic [trd_pkg::BYTE_W-1:0]  i_rep_byte6,
    output trd_pkg::t_touch             o_touch
);

    localparam logic [trd_pkg::PORT_COORD_W-1:0] MASK = trd_pkg::coord_mask(COORD_BITS);

    function automatic logic count_ok(input logic [trd_pkg::BYTE_W-1:0] b);
        return (b[3:0] >= trd_pkg::COUNT_MIN) && (b[3:0] <= trd_pkg::COUNT_MAX);
    endfunction

    function automatic logic [trd_pkg::PORT_COORD_W-1:0] coord(
        input logic [trd_pkg::BYTE_W-1:0] hi,
        input logic [trd_pkg::BYTE_W-1:0] lo
    );
        return {hi[3:0], lo} & MASK;
    endfunction

    // first valid count byte wins: byte 2, then 1, then 0
    always_comb begin
        o_touch = '0;
        if (i_read_ok) begin
            priority if (count_ok(i_rep_byte2)) begin
                o_touch.flag = 1'b1;
                o_touch.x    = coord(i_rep_byte3, i_rep_byte4);
                o_touch.y    = coord(i_rep_byte5, i_rep_byte6);
            end else if (count_ok(i_rep_byte1)) begin
                o_touch.flag = 1'b1;
                o_touch.x    = coord(i_rep_byte2, i_rep_byte3);
                o_touch.y    = coord(i_rep_byte4, i_rep_byte5);
            end else if (count_ok(i_rep_byte0)) begin
                o_touch.flag = 1'b1;
                o_touch.x    = coord(i_rep_byte1, i_rep_byte2);
                o_touch.y    = coord(i_rep_byte3, i_rep_byte4);
            end else begin
                o_touch = '0;
            end
        end
    end

endmodule

// ===== hw/rtl/trd_hold.sv =====
// ----------------------------------------------------------------------------
// trd_hold: press state and release hold timer
// Keeps the last pressed point and times the hold window after a release.
// ----------------------------------------------------------------------------
module trd_hold (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  trd_pkg::t_touch               i_touch,
    input  logic [trd_pkg::TIME_W-1:0]    i_now_ms,
    input  logic [trd_pkg::HOLD_W-1:0]    i_hold_ms,
    output trd_pkg::t_touch               o_state
);

    logic                              r_holding, n_holding;
    logic                              r_pending, n_pending;
    logic [trd_pkg::TIME_W-1:0]        r_start,   n_start;
    logic [trd_pkg::PORT_COORD_W-1:0]  r_last_x,  n_last_x;
    logic [trd_pkg::PORT_COORD_W-1:0]  r_last_y,  n_last_y;
    logic [trd_pkg::TIME_W-1:0]        w_start;
    logic [trd_pkg::TIME_W-1:0]        w_elapsed;
    logic                              w_in_hold;
    logic                              w_active;

    // hold window check, wrapping time
    assign w_start   = r_pending ? r_start : i_now_ms;
    assign w_elapsed = i_now_ms - w_start;
    assign w_in_hold = w_elapsed < {{(trd_pkg::TIME_W - trd_pkg::HOLD_W){1'b0}}, i_hold_ms};

    // next state
    always_comb begin
        n_holding = r_holding;
        n_pending = r_pending;
        n_start   = r_start;
        n_last_x  = r_last_x;
        n_last_y  = r_last_y;
        w_active  = 1'b0;
        priority if (i_touch.flag) begin
            n_pending = 1'b0;
            n_holding = 1'b1;
            n_last_x  = i_touch.x;
            n_last_y  = i_touch.y;
            w_active  = 1'b1;
        end else if (r_holding) begin
            n_start = w_start;
            if (w_in_hold) begin
                n_pending = 1'b1;
                w_active  = 1'b1;
            end else begin
                n_holding = 1'b0;
                n_pending = 1'b0;
            end
        end else begin
            w_active = 1'b0;
        end
    end

    // point seen by this word
    assign o_state.flag = w_active;
    assign o_state.x    = n_last_x;
    assign o_state.y    = n_last_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holding <= 1'b0;
            r_pending <= 1'b0;
            r_start   <= '0;
            r_last_x  <= '0;
            r_last_y  <= '0;
        end else if (i_en) begin
            r_holding <= n_holding;
            r_pending <= n_pending;
            r_start   <= n_start;
            r_last_x  <= n_last_x;
            r_last_y  <= n_last_y;
        end
    end

endmodule

// ===== hw/rtl/trd_xform.sv =====
// ----------------------------------------------------------------------------
// trd_xform: output point transform
// Mirrors each axis against its limit, saturating at zero, then swaps axes.
// ----------------------------------------------------------------------------
module trd_xform (
    input  trd_pkg::t_cfg    i_cfg,
    input  trd_pkg::t_touch  i_state,
    output trd_pkg::t_touch  o_point
);

    logic [trd_pkg::PORT_COORD_W-1:0] w_fx;
    logic [trd_pkg::PORT_COORD_W-1:0] w_fy;

    function automatic logic [trd_pkg::PORT_COORD_W-1:0] mirror(
        input logic [trd_pkg::PORT_COORD_W-1:0] v,
        input logic [trd_pkg::PORT_COORD_W-1:0] lim
    );
        return (v <= lim) ? (lim - v) : '0;
    endfunction

    // mirror per axis
    assign w_fx = i_cfg.mirror_x_en ? mirror(i_state.x, i_cfg.x_limit) : i_state.x;
    assign w_fy = i_cfg.mirror_y_en ? mirror(i_state.y, i_cfg.y_limit) : i_state.y;

    // swap, zero point when released
    always_comb begin
        o_point = '0;
        if (i_state.flag) begin
            o_point.flag = 1'b1;
            o_point.x    = i_cfg.swap_axes ? w_fy : w_fx;
            o_point.y    = i_cfg.swap_axes ? w_fx : w_fy;
        end
    end

endmodule
